// File: hdl/block_table_heap_allocator_macros.svh
// Assertion helpers shared by the allocator RTL.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef BLOCK_TABLE_HEAP_ALLOCATOR_MACROS_SVH
`define BLOCK_TABLE_HEAP_ALLOCATOR_MACROS_SVH

// The condition implies the property in the same cycle.
`define BTA_ASSERT_IMP(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// The condition implies the property in the following cycle.
`define BTA_ASSERT_NXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// File: hdl/bta_pkg.sv
package bta_pkg;

    // Width of one block table entry.
    localparam int MARK_W = 3;

    // Entry marks.
    localparam logic [MARK_W-1:0] MARK_TAKEN = 3'b001;
    localparam logic [MARK_W-1:0] MARK_FIRST = 3'b010;
    localparam logic [MARK_W-1:0] MARK_NEXT  = 3'b100;
    localparam logic [7:0]        TYPE_MASK  = 8'h0f;

    // Request kinds.
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOMEM = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_IN_USE = 1'b1;
    localparam int BIU_W = 11;

    // Shared arithmetic unit operations.
    localparam logic ALU_ADD = 1'b0;
    localparam logic ALU_SUB = 1'b1;

    // Flags returned by the shared arithmetic unit.
    typedef struct packed {
        logic carry;
        logic zero;
    } alu_flags_t;

endpackage

// File: hdl/bta_table.sv
module bta_table #(
    parameter int DEPTH = 1024,
    parameter int IDX_W = 10
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [IDX_W-1:0]           waddr,
    input  logic [bta_pkg::MARK_W-1:0] wdata,
    input  logic                       re,
    input  logic [IDX_W-1:0]           raddr,
    output logic [bta_pkg::MARK_W-1:0] rdata
);

    logic [bta_pkg::MARK_W-1:0] mem [DEPTH];
    logic [bta_pkg::MARK_W-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/bta_alu.sv
module bta_alu #(
    parameter int UW = 32
) (
    input  logic                op,
    input  logic [UW-1:0]       a,
    input  logic [UW-1:0]       b,
    output logic [UW-1:0]       result,
    output bta_pkg::alu_flags_t flags
);

    logic [UW:0] sum;

    // Add or subtract; the top bit is the carry or the borrow.
    always_comb
    begin
        unique case (op)
            bta_pkg::ALU_ADD: sum = {1'b0, a} + {1'b0, b};
            bta_pkg::ALU_SUB: sum = {1'b0, a} - {1'b0, b};
            default:          sum = '0;
        endcase
    end

    assign result      = sum[UW-1:0];
    assign flags.carry = sum[UW];
    assign flags.zero  = (sum[UW-1:0] == '0);

endmodule

// File: hdl/block_table_heap_allocator.sv
// Channel  Direction  Handshake                 Payload
// in       input      in_valid / in_ready       mode, size_bytes, free_address
// out      output     out_valid / out_ready     address, status
// cfg      input      cfg_write (no wait)       cfg_index, cfg_data
//
// After reset the block table is cleared one entry a cycle, with in_ready low;
// configuration writes are taken during that pass.
// An allocation scans for a free run of blocks, then marks each block of the
// run, forms the address and writes the result.
// A free subtracts the heap base, locates the block (one subtract per block
// on the shared unit), then reads and clears each entry of its chain.
// One request is worked at a time; a stalled result waits in the output
// register while the next request is accepted and worked.
`include "block_table_heap_allocator_macros.svh"

module block_table_heap_allocator #(
    parameter int NUM_BLOCKS = 1024,
    parameter int BLOCK_SIZE = 4096,
    parameter int ADDR_WIDTH = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               mode,
    input  logic [31:0]                        size_bytes,
    input  logic [31:0]                        free_address,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [31:0]                        address,
    output logic [1:0]                         status,
    input  logic                               cfg_write,
    input  logic [bta_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bta_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
    localparam int MW    = (CNT_W > bta_pkg::BIU_W) ? CNT_W : bta_pkg::BIU_W;
    localparam int UW    = (ADDR_WIDTH > 32) ? ADDR_WIDTH : 32;
    localparam int BS_W  = $clog2(BLOCK_SIZE + 1);
    localparam int PW    = IDX_W + BS_W;
    localparam logic [64:0]    AM_FULL  = (65'(1) << ADDR_WIDTH) - 65'(1);
    localparam logic [UW-1:0]  AMASK    = AM_FULL[UW-1:0];
    localparam logic [UW-1:0]  BS_U     = UW'(BLOCK_SIZE);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BLOCKS - 1);

    // Sequencer states.
    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_ASCAN  = 4'd2;
    localparam logic [3:0] S_AMARK  = 4'd3;
    localparam logic [3:0] S_AADDR  = 4'd4;
    localparam logic [3:0] S_FSUB   = 4'd5;
    localparam logic [3:0] S_FFIND  = 4'd6;
    localparam logic [3:0] S_CREAD  = 4'd7;
    localparam logic [3:0] S_CCLR   = 4'd8;
    localparam logic [3:0] S_RESULT = 4'd9;

    logic [3:0] state_reg, state_next;
    logic [31:0] heap_base_reg;
    logic [bta_pkg::BIU_W-1:0] blocks_in_use_reg;
    logic out_valid_reg;
    logic [31:0] address_reg;
    logic [1:0] status_reg;
    logic pend_reg, pend_next;
    logic run_reg, run_next;
    logic [IDX_W-1:0] widx_reg, widx_next;
    logic [UW-1:0] rem_reg, rem_next;
    logic [UW-1:0] size_reg, size_next;
    logic [IDX_W-1:0] first_reg, first_next;
    logic [IDX_W-1:0] last_reg, last_next;
    logic [IDX_W-1:0] ridx_reg, ridx_next;
    logic [IDX_W-1:0] eidx_reg;
    logic [CNT_W-1:0] fidx_reg, fidx_next;
    logic [IDX_W-1:0] cidx_reg, cidx_next;
    logic [UW-1:0] res_addr_reg, res_addr_next;
    logic [1:0] res_status_reg, res_status_next;
    logic [UW-1:0] prod_reg;
    logic [PW-1:0] prod_full;

    logic tbl_we, tbl_re;
    logic [IDX_W-1:0] tbl_waddr, tbl_raddr;
    logic [bta_pkg::MARK_W-1:0] tbl_wdata, tbl_rdata, mark_rd;
    logic alu_op;
    logic [UW-1:0] alu_a, alu_b, alu_result;
    bta_pkg::alu_flags_t alu_flags;

    logic accept, load_out, taken, has_next, last_entry, chain_more;
    logic [MW-1:0] biu_ext;
    logic [CNT_W-1:0] managed;
    logic [UW-1:0] base_u, faddr_u;

    bta_table #(
        .DEPTH (NUM_BLOCKS),
        .IDX_W (IDX_W)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .re    (tbl_re),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    bta_alu #(
        .UW (UW)
    ) u_alu (
        .op     (alu_op),
        .a      (alu_a),
        .b      (alu_b),
        .result (alu_result),
        .flags  (alu_flags)
    );

    // Managed entry count, limited to the table depth.
    assign biu_ext = MW'(blocks_in_use_reg);
    assign managed = (biu_ext > MW'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS) : CNT_W'(biu_ext);

    // Addresses reduced to the address width.
    assign base_u  = UW'(heap_base_reg) & AMASK;
    assign faddr_u = UW'(free_address) & AMASK;

    // Decoded marks of the entry read last cycle.
    assign mark_rd  = tbl_rdata & bta_pkg::TYPE_MASK[bta_pkg::MARK_W-1:0];
    assign taken    = |(mark_rd & bta_pkg::MARK_TAKEN);
    assign has_next = |(mark_rd & bta_pkg::MARK_NEXT);

    assign last_entry = (CNT_W'(eidx_reg) + CNT_W'(1)) == managed;
    assign chain_more = (CNT_W'(cidx_reg) + CNT_W'(1)) < managed;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign load_out = (state_reg == S_RESULT) && (!out_valid_reg || out_ready);

    // Byte offset of the chosen start block.
    assign prod_full = PW'(first_reg) * PW'(BLOCK_SIZE);

    // Sequencer and datapath next values.
    always_comb
    begin
        state_next      = state_reg;
        pend_next       = 1'b0;
        run_next        = run_reg;
        widx_next       = widx_reg;
        rem_next        = rem_reg;
        size_next       = size_reg;
        first_next      = first_reg;
        last_next       = last_reg;
        ridx_next       = ridx_reg;
        fidx_next       = fidx_reg;
        cidx_next       = cidx_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        tbl_we          = 1'b0;
        tbl_waddr       = widx_reg;
        tbl_wdata       = '0;
        tbl_re          = 1'b0;
        tbl_raddr       = ridx_reg;
        alu_op          = bta_pkg::ALU_SUB;
        alu_a           = rem_reg;
        alu_b           = BS_U;

        unique case (state_reg)
            S_CLEAR:
            begin
                tbl_we    = 1'b1;
                widx_next = widx_reg + IDX_W'(1);
                if (widx_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    res_addr_next   = '0;
                    res_status_next = bta_pkg::ST_OK;
                    size_next       = UW'(size_bytes);
                    run_next        = 1'b0;
                    ridx_next       = '0;
                    if (mode == bta_pkg::MODE_FREE)
                    begin
                        rem_next   = faddr_u;
                        state_next = S_FSUB;
                    end
                    else
                    begin
                        rem_next = UW'(size_bytes);
                        if (size_bytes == '0 || managed == '0)
                        begin
                            res_status_next = bta_pkg::ST_NOMEM;
                            state_next      = S_RESULT;
                        end
                        else
                        begin
                            state_next = S_ASCAN;
                        end
                    end
                end
            end

            S_ASCAN:
            begin
                // Reads run one entry ahead of the evaluation.
                tbl_re    = 1'b1;
                ridx_next = ridx_reg + IDX_W'(1);
                pend_next = 1'b1;
                if (pend_reg)
                begin
                    if (taken)
                    begin
                        run_next = 1'b0;
                        rem_next = size_reg;
                        if (last_entry)
                        begin
                            res_status_next = bta_pkg::ST_NOMEM;
                            state_next      = S_RESULT;
                        end
                    end
                    else
                    begin
                        if (!run_reg)
                        begin
                            first_next = eidx_reg;
                        end
                        run_next = 1'b1;
                        if (alu_flags.carry || alu_flags.zero)
                        begin
                            // The run now covers the requested size.
                            last_next  = eidx_reg;
                            widx_next  = run_reg ? first_reg : eidx_reg;
                            state_next = S_AMARK;
                        end
                        else
                        begin
                            rem_next = alu_result;
                            if (last_entry)
                            begin
                                res_status_next = bta_pkg::ST_NOMEM;
                                state_next      = S_RESULT;
                            end
                        end
                    end
                end
            end

            S_AMARK:
            begin
                tbl_we    = 1'b1;
                tbl_wdata = bta_pkg::MARK_TAKEN
                          | ((widx_reg == first_reg) ? bta_pkg::MARK_FIRST : '0)
                          | ((widx_reg != last_reg) ? bta_pkg::MARK_NEXT : '0);
                widx_next = widx_reg + IDX_W'(1);
                if (widx_reg == last_reg)
                begin
                    state_next = S_AADDR;
                end
            end

            S_AADDR:
            begin
                alu_op        = bta_pkg::ALU_ADD;
                alu_a         = base_u;
                alu_b         = prod_reg;
                res_addr_next = alu_result & AMASK;
                state_next    = S_RESULT;
            end

            S_FSUB:
            begin
                alu_b = base_u;
                if (alu_flags.carry)
                begin
                    res_status_next = bta_pkg::ST_RANGE;
                    state_next      = S_RESULT;
                end
                else
                begin
                    rem_next   = alu_result;
                    fidx_next  = '0;
                    state_next = S_FFIND;
                end
            end

            S_FFIND:
            begin
                // Subtract one block per cycle to find the block index.
                if (fidx_reg == managed)
                begin
                    res_status_next = bta_pkg::ST_RANGE;
                    state_next      = S_RESULT;
                end
                else if (alu_flags.carry)
                begin
                    cidx_next  = fidx_reg[IDX_W-1:0];
                    state_next = S_CREAD;
                end
                else
                begin
                    rem_next  = alu_result;
                    fidx_next = fidx_reg + CNT_W'(1);
                end
            end

            S_CREAD:
            begin
                tbl_re     = 1'b1;
                tbl_raddr  = cidx_reg;
                state_next = S_CCLR;
            end

            S_CCLR:
            begin
                tbl_we    = 1'b1;
                tbl_waddr = cidx_reg;
                if (has_next && chain_more)
                begin
                    cidx_next = cidx_reg + IDX_W'(1);
                    tbl_re    = 1'b1;
                    tbl_raddr = cidx_reg + IDX_W'(1);
                end
                else
                begin
                    state_next = S_RESULT;
                end
            end

            S_RESULT:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_CLEAR;
            widx_reg          <= '0;
            pend_reg          <= 1'b0;
            run_reg           <= 1'b0;
            out_valid_reg     <= 1'b0;
            heap_base_reg     <= '0;
            blocks_in_use_reg <= bta_pkg::BIU_W'(1024);
        end
        else
        begin
            state_reg <= state_next;
            widx_reg  <= widx_next;
            pend_reg  <= pend_next;
            run_reg   <= run_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    bta_pkg::REG_HEAP_BASE:     heap_base_reg     <= cfg_data;
                    bta_pkg::REG_BLOCKS_IN_USE: blocks_in_use_reg <= cfg_data[bta_pkg::BIU_W-1:0];
                    default:                    ;
                endcase
            end
        end
    end

    // Datapath and result registers.
    always_ff @(posedge clk)
    begin
        rem_reg        <= rem_next;
        size_reg       <= size_next;
        first_reg      <= first_next;
        last_reg       <= last_next;
        ridx_reg       <= ridx_next;
        eidx_reg       <= ridx_reg;
        fidx_reg       <= fidx_next;
        cidx_reg       <= cidx_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        prod_reg       <= UW'(prod_full);
        if (load_out)
        begin
            address_reg <= res_addr_reg[31:0];
            status_reg  <= res_status_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign address   = address_reg;
    assign status    = status_reg;

    `BTA_ASSERT_IMP(a_table_write_state, tbl_we, state_reg == S_CLEAR || state_reg == S_AMARK || state_reg == S_CCLR, "block table written outside clear, mark or chain states")
    `BTA_ASSERT_IMP(a_fail_zero_address, out_valid_reg && status_reg != bta_pkg::ST_OK, address_reg == '0, "failed transaction carries a nonzero address")
    `BTA_ASSERT_IMP(a_mark_in_run, state_reg == S_AMARK, widx_reg >= first_reg && widx_reg <= last_reg, "mark pointer left the chosen run")
    `BTA_ASSERT_NXT(a_result_handoff, load_out, out_valid_reg && state_reg == S_IDLE, "result not handed to the output register")

endmodule
